// File: rtl/core/bbfa_pkg.sv
// shared types and constants for the big-endian bit-field access block
// no dependencies; imported by the top level, the front end and the back end
package bbfa_pkg;

	localparam int unsigned WORD_BITS    = 64;
	localparam int unsigned WINDOW_BYTES = 8;
	localparam int unsigned LANE_BITS    = 3;
	localparam int unsigned SHIFT_BITS   = 6;
	localparam logic [WORD_BITS-1:0] WORD_ONES = '1;

	typedef enum logic {
		OP_READ  = 1'b0,
		OP_WRITE = 1'b1
	} bbfa_op_t;

	typedef struct packed {
		logic        operation;
		logic [7:0]  byte_position;
		logic [6:0]  bit_length;
		logic [2:0]  bit_offset;
		logic [63:0] write_value;
	} bbfa_req_t;

	typedef struct packed {
		logic [63:0] read_value;
		logic        error;
	} bbfa_rsp_t;

	// classified request handed from front to back
	typedef struct packed {
		logic                  operation;
		logic                  active;
		logic                  error;
		logic [7:0]            position;
		logic [SHIFT_BITS-1:0] shift;
		logic [WORD_BITS-1:0]  mask;
		logic [WORD_BITS-1:0]  insert;
	} bbfa_cmd_t;

	typedef enum logic {
		BK_ISSUE = 1'b0,
		BK_EXEC  = 1'b1
	} bbfa_bk_state_t;

endpackage

// File: rtl/core/byte_buffer_bitfield_access.sv
// top level of the big-endian bit-field access block
// depends on bbfa_pkg, bbfa_front, bbfa_queue and bbfa_back
//
// usage
//   request side is a queue: drive req and raise push; the beat is taken on a
//   rising edge with push high and full low
//   result side is a queue: the oldest result sits on rsp while empty is low;
//   raise pop to take it, taken on a rising edge with pop high and empty low
//   every request gives exactly one result, in request order
// request flow
//   a request is enqueued in the command queue, then its bank read is issued,
//   then it executes and its result is pushed into the result queue
//   the back end reads the eight byte banks for a request, then merges and
//   writes back; it takes no new request until the last one is written back
// stalls
//   a two-entry command queue parts front and back, a two-entry result queue
//   parts back and receiver; when the receiver stalls both fill and full rises
// reset
//   arst_n clears queues and sequencer; per-byte written flags make the whole
//   store read as zero at once, with no clearing pass
module byte_buffer_bitfield_access
	import bbfa_pkg::*;
#(
	parameter int unsigned STORE_BYTES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  bbfa_req_t req,
	output logic      empty,
	input  logic      pop,
	output bbfa_rsp_t rsp
);

	localparam int unsigned CMD_W = $bits(bbfa_cmd_t);
	localparam int unsigned RSP_W = $bits(bbfa_rsp_t);

	// classified request from the front end
	bbfa_cmd_t front_cmd;
	bbfa_cmd_t back_cmd;
	logic      cmd_empty, cmd_pop;

	// result beat from the back end
	bbfa_rsp_t back_rsp;
	logic      rsp_full, rsp_push;

	logic [CMD_W-1:0] cmd_dout;
	logic [RSP_W-1:0] rsp_dout;

	bbfa_front #(
		.STORE_BYTES (STORE_BYTES)
	) u_front (
		.req (req),
		.cmd (front_cmd)
	);

	// command queue between front and back
	bbfa_queue #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (front_cmd),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cmd_dout),
		.empty  (cmd_empty)
	);

	assign back_cmd = bbfa_cmd_t'(cmd_dout);

	bbfa_back #(
		.STORE_BYTES (STORE_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.rsp       (back_rsp),
		.rsp_full  (rsp_full),
		.rsp_push  (rsp_push)
	);

	// result queue towards the receiver
	bbfa_queue #(
		.WIDTH (RSP_W),
		.DEPTH (2)
	) u_rsp_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rsp_push),
		.din    (back_rsp),
		.full   (rsp_full),
		.pop    (pop),
		.dout   (rsp_dout),
		.empty  (empty)
	);

	assign rsp = bbfa_rsp_t'(rsp_dout);

endmodule

// File: rtl/core/bbfa_queue.sv
// small synchronous fifo with registered storage
// depends on nothing; used for the command and result queues
module bbfa_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULLC = CW'(DEPTH);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == FULLC);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: rtl/core/bbfa_front.sv
// front end: range checks and field mask / insert value preparation
// depends on bbfa_pkg
module bbfa_front
	import bbfa_pkg::*;
#(
	parameter int unsigned STORE_BYTES = 256
) (
	input  bbfa_req_t req,
	output bbfa_cmd_t cmd
);

	localparam logic [16:0] STORE_LIMIT = 17'(STORE_BYTES);

	logic [7:0]  fld_end;
	logic [16:0] win_end;
	logic        win_err, fld_err;
	logic [6:0]  shift_w, rsh_w;
	logic [63:0] mask;

	always_comb begin
		fld_end = {5'b0, req.bit_offset} + {1'b0, req.bit_length};
		win_end = {9'b0, req.byte_position} + 17'(WINDOW_BYTES);
		win_err = (win_end > STORE_LIMIT);
		fld_err = (fld_end > 8'(WORD_BITS));
		// lsb of the field inside the big-endian word
		shift_w = 7'(WORD_BITS) - fld_end[6:0];
		rsh_w   = 7'(WORD_BITS) - req.bit_length;
		mask    = (WORD_ONES >> rsh_w[SHIFT_BITS-1:0]) << shift_w[SHIFT_BITS-1:0];

		cmd.operation = req.operation;
		cmd.error     = win_err || fld_err;
		cmd.active    = !(win_err || fld_err) && (req.bit_length != 7'd0);
		cmd.position  = req.byte_position;
		cmd.shift     = shift_w[SHIFT_BITS-1:0];
		cmd.mask      = mask;
		cmd.insert    = (req.write_value << shift_w[SHIFT_BITS-1:0]) & mask;
	end

endmodule

// File: rtl/core/bbfa_back.sv
// back end: byte-banked store with read-modify-write of the 8-byte window
// depends on bbfa_pkg
module bbfa_back
	import bbfa_pkg::*;
#(
	parameter int unsigned STORE_BYTES = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  bbfa_cmd_t cmd,
	input  logic      cmd_empty,
	output logic      cmd_pop,
	output bbfa_rsp_t rsp,
	input  logic      rsp_full,
	output logic      rsp_push
);

	// highest byte a window can reach is 255 + 7
	localparam int unsigned USED_BYTES = (STORE_BYTES < 264) ? STORE_BYTES : 264;
	localparam int unsigned ROWS = (USED_BYTES + WINDOW_BYTES - 1) / WINDOW_BYTES;
	localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;

	bbfa_bk_state_t state_q, state_d;
	bbfa_cmd_t      cmd_q;
	logic           issue;

	logic [RW-1:0]  row     [WINDOW_BYTES];
	logic [RW-1:0]  row_q   [WINDOW_BYTES];
	logic [7:0]     rdata_q [WINDOW_BYTES];
	logic           rvld_q  [WINDOW_BYTES];
	logic [7:0]     wdata   [WINDOW_BYTES];
	logic           wr_en;

	logic [63:0]    word, new_word;

	// sequencer: issue bank reads, then execute and write back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_ISSUE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		issue    = 1'b0;
		rsp_push = 1'b0;
		case (state_q)
			BK_ISSUE: begin
				if (!cmd_empty && !rsp_full) begin
					issue   = 1'b1;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				rsp_push = 1'b1;
				state_d  = BK_ISSUE;
			end
			default: begin
				state_d = BK_ISSUE;
			end
		endcase
	end

	assign cmd_pop = issue;
	assign wr_en   = (state_q == BK_EXEC) && cmd_q.active && (cmd_q.operation == OP_WRITE);

	always_ff @(posedge clk) begin
		if (issue) begin
			cmd_q <= cmd;
		end
	end

	// row of each bank touched by the window
	always_comb begin
		logic [2:0] k;
		logic [8:0] addr;
		for (int b = 0; b < WINDOW_BYTES; b++) begin
			k      = 3'(b) - cmd.position[2:0];
			addr   = {1'b0, cmd.position} + {6'b0, k};
			row[b] = addr[3 +: RW];
		end
	end

	genvar gb;
	generate
		for (gb = 0; gb < WINDOW_BYTES; gb++) begin : g_bank
			logic [7:0]      mem [ROWS];
			logic [ROWS-1:0] vld_q;

			always_ff @(posedge clk) begin
				if (issue && cmd.active) begin
					rdata_q[gb] <= mem[row[gb]];
				end
				if (issue) begin
					row_q[gb] <= row[gb];
				end
				if (wr_en) begin
					mem[row_q[gb]] <= wdata[gb];
				end
			end

			// written flags so the store reads as zero after reset
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q       <= '0;
					rvld_q[gb]  <= 1'b0;
				end else begin
					if (issue && cmd.active) begin
						rvld_q[gb] <= vld_q[row[gb]];
					end
					if (wr_en) begin
						vld_q[row_q[gb]] <= 1'b1;
					end
				end
			end
		end
	endgenerate

	// gather the window big-endian and scatter the merged word back
	always_comb begin
		logic [2:0] lane, k;
		word = '0;
		for (int i = 0; i < WINDOW_BYTES; i++) begin
			lane = cmd_q.position[2:0] + 3'(i);
			word[63 - 8*i -: 8] = rvld_q[lane] ? rdata_q[lane] : 8'h00;
		end
		new_word = (word & ~cmd_q.mask) | cmd_q.insert;
		for (int b = 0; b < WINDOW_BYTES; b++) begin
			k        = 3'(b) - cmd_q.position[2:0];
			wdata[b] = new_word[63 - 8*k -: 8];
		end
	end

	always_comb begin
		rsp.error      = cmd_q.error;
		rsp.read_value = (cmd_q.active && cmd_q.operation == OP_READ)
			? ((word & cmd_q.mask) >> cmd_q.shift) : 64'd0;
	end

endmodule
